// ----- hw/rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin time-slice scheduler.
// Used by rrts_ctrl, rrts_dp and the top level; depends on nothing else.
package rrts_pkg;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int TICK_W  = 32;
    localparam int SLICE_W = 8;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;
    localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;
    localparam logic [TICK_W-1:0]  TICK_MAX    = 32'hFFFF_FFFF;

    // One ready-queue entry.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic [TICK_W-1:0]  arrival;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic push;       // append an arriving process
        logic read_head;  // fetch the head entry
        logic rotate;     // move the head entry to the tail
        logic run;        // run the head for one tick
        logic report;     // emit the completion result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic rotate_due;
        logic finishing;
    } status_t;

endpackage

// ----- hw/rtl/rrts_ctrl.sv -----
// Sequencer for the round-robin time-slice scheduler.
// Depends on rrts_pkg for the command and status structs.
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    func,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_TICK)
                    begin
                        cmd.read_head = 1'b1;
                        state_next    = ST_EXEC;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_head = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.rotate_due)
                begin
                    // refetch the new head once the copy has landed
                    cmd.rotate = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.run    = 1'b1;
                    state_next = status.finishing ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- hw/rtl/rrts_dp.sv -----
// Datapath of the round-robin time-slice scheduler: ready-queue memory,
// pointers, tick and slice counters, result registers. Depends on rrts_pkg.
module rrts_dp
    import rrts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [ID_W-1:0]    proc_id,
    input  logic [BURST_W-1:0] burst_len,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] time_slice,
    output logic               result_valid,
    output logic               rejected,
    output logic               ran,
    output logic [ID_W-1:0]    run_id,
    output logic               finished,
    output logic [TICK_W-1:0]  turnaround,
    output logic [TICK_W-1:0]  waiting
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_reg;

    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    logic [PTR_W-1:0]   head_reg,       head_next;
    logic [PTR_W-1:0]   tail_reg,       tail_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [SLICE_W-1:0] slice_used_reg, slice_used_next;
    logic               running_reg,    running_next;
    logic [TICK_W-1:0]  now_reg,        now_next;
    logic [SLICE_W-1:0] slice_reg;
    logic [TICK_W-1:0]  elapsed_reg,    elapsed_next;

    logic               valid_reg,      valid_next;
    logic               rejected_reg,   rejected_next;
    logic               ran_reg,        ran_next;
    logic [ID_W-1:0]    run_id_reg,     run_id_next;
    logic               finished_reg,   finished_next;
    logic [TICK_W-1:0]  turnaround_reg, turnaround_next;
    logic [TICK_W-1:0]  waiting_reg,    waiting_next;

    logic               queue_empty;
    logic               queue_full;
    logic [SLICE_W-1:0] slice_eff;
    logic [SLICE_W-1:0] slice_base;
    logic [TICK_W-1:0]  tick_done;
    logic [TICK_W-1:0]  burst_ext;
    logic [BURST_W-1:0] burst_fixed;

    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == FULL_COUNT);
    assign slice_eff   = (slice_reg == '0) ? SLICE_W'(1) : slice_reg;
    assign slice_base  = running_reg ? slice_used_reg : '0;
    assign tick_done   = (now_reg == TICK_MAX) ? now_reg : now_reg + 1'b1;
    assign burst_ext   = {{(TICK_W - BURST_W){1'b0}}, rd_reg.burst};
    assign burst_fixed = (burst_len == '0) ? BURST_W'(1) : burst_len;

    assign status.rotate_due = running_reg && !queue_empty
                               && (slice_used_reg >= slice_eff);
    assign status.finishing  = !queue_empty && (rd_reg.remaining <= BURST_W'(1));

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        slice_used_next = slice_used_reg;
        running_next    = running_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;

        valid_next      = 1'b0;
        rejected_next   = rejected_reg;
        ran_next        = ran_reg;
        run_id_next     = run_id_reg;
        finished_next   = finished_reg;
        turnaround_next = turnaround_reg;
        waiting_next    = waiting_reg;

        mem_we          = 1'b0;
        mem_waddr       = tail_reg;
        mem_wdata       = rd_reg;

        if (cmd.push)
        begin
            valid_next      = 1'b1;
            rejected_next   = queue_full;
            ran_next        = 1'b0;
            run_id_next     = '0;
            finished_next   = 1'b0;
            turnaround_next = '0;
            waiting_next    = '0;
            if (!queue_full)
            begin
                mem_we              = 1'b1;
                mem_wdata.id        = proc_id;
                mem_wdata.remaining = burst_fixed;
                mem_wdata.burst     = burst_fixed;
                mem_wdata.arrival   = now_reg;
                tail_next           = next_slot(tail_reg);
                count_next          = count_reg + 1'b1;
            end
        end
        else if (cmd.rotate)
        begin
            mem_we          = 1'b1;
            head_next       = next_slot(head_reg);
            tail_next       = next_slot(tail_reg);
            running_next    = 1'b0;
            slice_used_next = '0;
        end
        else if (cmd.run)
        begin
            now_next        = tick_done;
            rejected_next   = 1'b0;
            finished_next   = 1'b0;
            turnaround_next = '0;
            waiting_next    = '0;
            if (queue_empty)
            begin
                valid_next  = 1'b1;
                ran_next    = 1'b0;
                run_id_next = '0;
            end
            else if (status.finishing)
            begin
                // pop now, report on the next cycle
                elapsed_next    = tick_done - rd_reg.arrival;
                head_next       = next_slot(head_reg);
                count_next      = count_reg - 1'b1;
                running_next    = 1'b0;
                slice_used_next = '0;
            end
            else
            begin
                valid_next          = 1'b1;
                ran_next            = 1'b1;
                run_id_next         = rd_reg.id;
                mem_we              = 1'b1;
                mem_waddr           = head_reg;
                mem_wdata.remaining = rd_reg.remaining - 1'b1;
                running_next        = 1'b1;
                slice_used_next     = (slice_base == SLICE_MAX) ? SLICE_MAX
                                                               : slice_base + 1'b1;
            end
        end
        else if (cmd.report)
        begin
            valid_next      = 1'b1;
            rejected_next   = 1'b0;
            ran_next        = 1'b1;
            run_id_next     = rd_reg.id;
            finished_next   = 1'b1;
            turnaround_next = elapsed_reg;
            waiting_next    = (elapsed_reg >= burst_ext) ? elapsed_reg - burst_ext : '0;
        end
    end

    // Queue storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_head)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            slice_used_reg <= '0;
            running_reg    <= 1'b0;
            now_reg        <= '0;
            slice_reg      <= SLICE_RESET;
            valid_reg      <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            slice_used_reg <= slice_used_next;
            running_reg    <= running_next;
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            if (cfg_we)
            begin
                slice_reg <= time_slice;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg    <= elapsed_next;
        rejected_reg   <= rejected_next;
        ran_reg        <= ran_next;
        run_id_reg     <= run_id_next;
        finished_reg   <= finished_next;
        turnaround_reg <= turnaround_next;
        waiting_reg    <= waiting_next;
    end

    assign result_valid = valid_reg;
    assign rejected     = rejected_reg;
    assign ran          = ran_reg;
    assign run_id       = run_id_reg;
    assign finished     = finished_reg;
    assign turnaround   = turnaround_reg;
    assign waiting      = waiting_reg;

endmodule

// ----- hw/rtl/round_robin_time_slice_scheduler.sv -----
// Round-robin scheduler with a fixed time slice; one result per request.
// Arrival: accepted without raising busy, result strobed the next cycle; back-to-back arrivals.
// Tick: head fetch from the queue memory, then execute; a finishing process adds a
// report state for the waiting subtract, and a head that rotates first adds a copy to
// tail, then a refetch and execute. Result strobes in the same cycle that busy drops.
// Reset clears pointers, counters and the tick; time_slice returns to 4; no clearing pass.
module round_robin_time_slice_scheduler
    import rrts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [ID_W-1:0]    proc_id,
    input  logic [BURST_W-1:0] burst_len,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SLICE_W-1:0] time_slice,
    output logic               result_valid,
    output logic               rejected,
    output logic               ran,
    output logic [ID_W-1:0]    run_id,
    output logic               finished,
    output logic [TICK_W-1:0]  turnaround,
    output logic [TICK_W-1:0]  waiting
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = !busy;

    rrts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rrts_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .proc_id      (proc_id),
        .burst_len    (burst_len),
        .cfg_we       (cfg_valid && cfg_ready),
        .time_slice   (time_slice),
        .result_valid (result_valid),
        .rejected     (rejected),
        .ran          (ran),
        .run_id       (run_id),
        .finished     (finished),
        .turnaround   (turnaround),
        .waiting      (waiting)
    );

endmodule

// ----- hw/rtl/rrts_checker.sv -----
// Port-level checks for the round-robin time-slice scheduler, bound to the top level.
// Depends only on the top level's port names.
module rrts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        func,
    input logic        result_valid,
    input logic        rejected,
    input logic        ran,
    input logic        finished,
    input logic [31:0] turnaround,
    input logic [31:0] waiting
);

    // An arrival request answers on the very next cycle.
    a_arrive_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func) |=> result_valid)
        else $error("arrival result missing");

    // A tick request always holds busy, with no result yet, in the cycle after it is taken.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func) |=> (busy && !result_valid))
        else $error("tick did not hold busy");

    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && finished) |-> (ran && !rejected))
        else $error("finished without running");

    a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rejected) |-> (!ran && !finished))
        else $error("rejected arrival reported a run");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && finished) |-> (waiting <= turnaround))
        else $error("waiting exceeds turnaround");

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (.*);

// ----- dv/round_robin_time_slice_scheduler_test.sv -----
// Self-checking testbench for the round-robin time-slice scheduler.
// Drives arrivals and ticks, predicts each result in an in-bench scheduler copy.
// Depends on rrts_pkg and round_robin_time_slice_scheduler only.
module round_robin_time_slice_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrts_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic               rejected;
        logic               ran;
        logic [ID_W-1:0]    run_id;
        logic               finished;
        logic [TICK_W-1:0]  turnaround;
        logic [TICK_W-1:0]  waiting;
    } sched_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               func = FUNC_ARRIVE;
    logic [ID_W-1:0]    proc_id = '0;
    logic [BURST_W-1:0] burst_len = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SLICE_W-1:0] time_slice = SLICE_RESET;
    logic               result_valid;
    logic               rejected;
    logic               ran;
    logic [ID_W-1:0]    run_id;
    logic               finished;
    logic [TICK_W-1:0]  turnaround;
    logic [TICK_W-1:0]  waiting;

    // Scheduler state as the block should hold it
    logic [ID_W-1:0]    ready_id      [QUEUE_DEPTH];
    logic [BURST_W-1:0] ready_left    [QUEUE_DEPTH];
    logic [BURST_W-1:0] ready_burst   [QUEUE_DEPTH];
    logic [TICK_W-1:0]  ready_arrival [QUEUE_DEPTH];
    logic [IDX_W-1:0]   head_idx = '0;
    logic [IDX_W-1:0]   tail_idx = '0;
    logic [IDX_W:0]     occupancy = '0;
    logic [SLICE_W-1:0] slice_count = '0;
    logic               head_dispatched = 1'b0;
    logic [TICK_W-1:0]  tick_now = '0;
    logic [SLICE_W-1:0] slice_setting = SLICE_RESET;

    sched_result_t pending_outcomes[$];
    int unsigned   mismatch_count = 0;

    round_robin_time_slice_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .proc_id      (proc_id),
        .burst_len    (burst_len),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .time_slice   (time_slice),
        .result_valid (result_valid),
        .rejected     (rejected),
        .ran          (ran),
        .run_id       (run_id),
        .finished     (finished),
        .turnaround   (turnaround),
        .waiting      (waiting)
    );

    always #4 clk = ~clk;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic sched_result_t schedule_step(input logic f,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [BURST_W-1:0] blen);
        sched_result_t      r;
        logic [SLICE_W-1:0] eff_slice;
        logic [BURST_W-1:0] need;
        logic [TICK_W-1:0]  done_tick;
        logic [TICK_W-1:0]  span;
        logic [TICK_W-1:0]  burst_ext;
        r = '0;
        eff_slice = (slice_setting == '0) ? SLICE_W'(1) : slice_setting;
        if (f == FUNC_ARRIVE)
        begin
            if (occupancy >= QUEUE_DEPTH)
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                need = (blen == '0) ? BURST_W'(1) : blen;
                ready_id[tail_idx]      = id;
                ready_left[tail_idx]    = need;
                ready_burst[tail_idx]   = need;
                ready_arrival[tail_idx] = tick_now;
                tail_idx  = next_slot(tail_idx);
                occupancy = occupancy + 1'b1;
            end
        end
        else
        begin
            // rotate an expired head behind this tick's arrivals
            if (head_dispatched && occupancy != '0 && slice_count >= eff_slice)
            begin
                ready_id[tail_idx]      = ready_id[head_idx];
                ready_left[tail_idx]    = ready_left[head_idx];
                ready_burst[tail_idx]   = ready_burst[head_idx];
                ready_arrival[tail_idx] = ready_arrival[head_idx];
                head_idx        = next_slot(head_idx);
                tail_idx        = next_slot(tail_idx);
                head_dispatched = 1'b0;
                slice_count     = '0;
            end
            if (occupancy != '0)
            begin
                done_tick = (tick_now == TICK_MAX) ? tick_now : tick_now + 1'b1;
                if (!head_dispatched)
                begin
                    head_dispatched = 1'b1;
                    slice_count     = '0;
                end
                r.ran    = 1'b1;
                r.run_id = ready_id[head_idx];
                if (ready_left[head_idx] != '0)
                    ready_left[head_idx] = ready_left[head_idx] - 1'b1;
                if (slice_count != SLICE_MAX)
                    slice_count = slice_count + 1'b1;
                if (ready_left[head_idx] == '0)
                begin
                    span      = done_tick - ready_arrival[head_idx];
                    burst_ext = TICK_W'(ready_burst[head_idx]);
                    r.finished   = 1'b1;
                    r.turnaround = span;
                    r.waiting    = (span >= burst_ext) ? span - burst_ext : '0;
                    head_idx        = next_slot(head_idx);
                    occupancy       = occupancy - 1'b1;
                    head_dispatched = 1'b0;
                    slice_count     = '0;
                end
            end
            if (tick_now != TICK_MAX)
                tick_now = tick_now + 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string field_name, input logic [TICK_W-1:0] expected_v,
                               input logic [TICK_W-1:0] actual_v);
        if (expected_v !== actual_v)
        begin
            $error("%s: expected %0h, actual %0h", field_name, expected_v, actual_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        sched_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no request pending: run_id %0h", run_id);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_outcomes.pop_front();
                check_field("rejected", TICK_W'(exp_r.rejected), TICK_W'(rejected));
                check_field("ran", TICK_W'(exp_r.ran), TICK_W'(ran));
                check_field("run_id", TICK_W'(exp_r.run_id), TICK_W'(run_id));
                check_field("finished", TICK_W'(exp_r.finished), TICK_W'(finished));
                check_field("turnaround", exp_r.turnaround, turnaround);
                check_field("waiting", exp_r.waiting, waiting);
            end
        end
    end

    // Leave start high on return so back-to-back requests keep it asserted
    task automatic send_request(input logic f, input logic [ID_W-1:0] id,
                                input logic [BURST_W-1:0] blen);
        sched_result_t outcome;
        start     <= 1'b1;
        func      <= f;
        proc_id   <= id;
        burst_len <= blen;
        do
            @(posedge clk);
        while (busy);
        outcome = schedule_step(f, id, blen);
        pending_outcomes = {pending_outcomes, outcome};
    endtask

    task automatic send_tick();
        send_request(FUNC_TICK, ID_W'($urandom_range(255)), BURST_W'($urandom_range(65535)));
    endtask

    task automatic pause_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic await_drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    task automatic write_time_slice(input logic [SLICE_W-1:0] value);
        await_drain();
        cfg_valid  <= 1'b1;
        time_slice <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slice_setting = value;
    endtask

    // Top the queue up, then push a few arrivals that must bounce
    task automatic fill_queue(input int unsigned overflow);
        while (occupancy < QUEUE_DEPTH)
            send_request(FUNC_ARRIVE, ID_W'($urandom_range(255)),
                         BURST_W'($urandom_range(1, 6)));
        repeat (overflow)
            send_request(FUNC_ARRIVE, ID_W'($urandom_range(255)),
                         BURST_W'($urandom_range(65535)));
    endtask

    task automatic test_idle_and_zero_burst();
        send_tick();
        send_request(FUNC_ARRIVE, 8'h00, 16'h0000);
        send_tick();
    endtask

    task automatic test_lone_rotation();
        // run a full slice, rotate onto itself, then finish on a fresh slice
        send_request(FUNC_ARRIVE, 8'h3C, 16'd5);
        repeat (5) send_tick();
    endtask

    task automatic test_slice_change();
        send_request(FUNC_ARRIVE, 8'hFF, 16'hFFFF);
        send_request(FUNC_ARRIVE, 8'h5A, 16'd2);
        send_request(FUNC_ARRIVE, 8'hA5, 16'd1);
        write_time_slice(SLICE_MAX);
        repeat (3) send_tick();
        // head has already used more than the new slice
        write_time_slice(8'd2);
        send_tick();
        write_time_slice(8'd0);
        repeat (3) send_tick();
    endtask

    task automatic test_queue_full();
        int unsigned guard;
        fill_queue(2);
        send_request(FUNC_ARRIVE, 8'hFF, 16'hFFFF);
        send_request(FUNC_ARRIVE, 8'h00, 16'h0000);
        guard = 0;
        while (occupancy > 8 && guard < 400)
        begin
            send_tick();
            guard++;
        end
    endtask

    task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct);
        int unsigned        arrive_pct;
        logic [BURST_W-1:0] blen;
        repeat (items)
        begin
            if ($urandom_range(99) < idle_pct)
                pause_sender($urandom_range(1, 3));
            if ($urandom_range(99) < 2)
            begin
                fill_queue($urandom_range(1, 3));
            end
            else
            begin
                arrive_pct = (occupancy < 3) ? 50 : ((occupancy >= 12) ? 10 : 25);
                blen = ($urandom_range(99) < 85) ? BURST_W'($urandom_range(1, 6))
                                                 : BURST_W'($urandom_range(0, 40));
                if ($urandom_range(99) < arrive_pct)
                    send_request(FUNC_ARRIVE, ID_W'($urandom_range(255)), blen);
                else
                    send_tick();
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_zero_burst();
        test_lone_rotation();
        test_slice_change();
        test_queue_full();
        write_time_slice(8'd1);
        test_random_traffic(210, 0);
        write_time_slice(SLICE_MAX);
        test_random_traffic(210, 58);
        write_time_slice(SLICE_W'($urandom_range(2, 8)));
        test_random_traffic(210, 23);
        write_time_slice(8'd0);
        test_random_traffic(210, 0);
        write_time_slice(8'd3);
        test_random_traffic(210, 58);
        write_time_slice(SLICE_RESET);
        test_random_traffic(210, 23);
        await_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("round_robin_time_slice_scheduler: match");
        else
            $display("round_robin_time_slice_scheduler: mismatch");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("round_robin_time_slice_scheduler: mismatch");
        $finish;
    end

endmodule
